@@ rtl/pha_pkg.sv @@
// pha_pkg: shared types, constants and helpers of the pixel hit accumulator
// no dependencies
`timescale 1ns / 1ps

package pha_pkg;

    localparam int KEY_W = 48;
    localparam int CNT_W = 16;
    localparam int IDX_W = 16;

    localparam logic [2:0] CFG_PITCH_X  = 3'd0;
    localparam logic [2:0] CFG_PITCH_Y  = 3'd1;
    localparam logic [2:0] CFG_COLS     = 3'd2;
    localparam logic [2:0] CFG_ROWS     = 3'd3;
    localparam logic [2:0] CFG_CHIPS    = 3'd4;

    localparam logic ACT_HIT   = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] first;
    } entry_t;

    typedef struct packed {
        logic             update;
        logic             insert;
        logic             shift;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] first;
    } cell_ctrl_t;

    // zero reads as one
    function automatic logic [15:0] nz16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ rtl/pha_if.sv @@
// pha_if: valid/ready channels carrying hit beats and result beats
// depends on nothing
`timescale 1ns / 1ps

interface pha_hit_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] sensor_id;
    logic [15:0] local_x_um;
    logic [15:0] local_y_um;

    modport source (output valid, action, sensor_id, local_x_um, local_y_um, input ready);
    modport sink (input valid, action, sensor_id, local_x_um, local_y_um, output ready);
endinterface

interface pha_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_sensor_id;
    logic [15:0] chip_id;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_row;
    logic [15:0] hit_count;
    logic [15:0] first_hit_index;
    logic        entry_valid;
    logic        overflow;
    logic        last;

    modport source (output valid, out_sensor_id, chip_id, pixel_col, pixel_row, hit_count,
                    first_hit_index, entry_valid, overflow, last, input ready);
    modport sink (input valid, out_sensor_id, chip_id, pixel_col, pixel_row, hit_count,
                  first_hit_index, entry_valid, overflow, last, output ready);
endinterface

@@ rtl/pha_div.sv @@
// pha_div: 16 by 16 bit restoring divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps

module pha_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);
    logic [15:0] quot_reg;
    logic [15:0] rem_reg;
    logic [15:0] div_reg;
    logic [3:0]  step_reg;
    logic        run_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, quot_reg[15]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[14:0], ge};
            rem_reg  <= ge ? diff[15:0] : trial[15:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;
endmodule

@@ rtl/pha_cell.sv @@
// pha_cell: one event table entry, compares, counts, loads or takes its neighbour's entry
// depends on pha_pkg
`timescale 1ns / 1ps

module pha_cell
    import pha_pkg::*;
(
    input  logic       clk,
    input  logic       occ,
    input  logic       prev_occ,
    input  cell_ctrl_t ctrl,
    input  entry_t     nbr,
    output entry_t     ent,
    output logic       match
);
    entry_t ent_reg;

    assign match = occ && (ent_reg.key == ctrl.key);

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
            ent_reg <= nbr;
        else if (ctrl.insert && prev_occ && !occ)
        begin
            ent_reg.key   <= ctrl.key;
            ent_reg.count <= CNT_W'(1);
            ent_reg.first <= ctrl.first;
        end
        else if (ctrl.update && match && ent_reg.count != CNT_MAX)
            ent_reg.count <= ent_reg.count + CNT_W'(1);
    end

    assign ent = ent_reg;
endmodule

@@ rtl/pixel_hit_accumulator.sv @@
// pixel_hit_accumulator: top level, pixel address decode and event table as a chain of cells
// depends on pha_pkg, pha_if, pha_div, pha_cell
`timescale 1ns / 1ps

// usage
//   in_ch carries beats with action, sensor_id and local x/y in micrometres;
//   action hit updates the event table, action flush drains it
//   out_ch carries one beat per table entry on a flush, oldest entry first,
//   last set on the final beat; an empty flush gives one beat with entry_valid 0
//   cfg_we/cfg_index/cfg_data write pitches and chip geometry while idle
// timing
//   one item at a time; a hit makes two passes through the bit-serial
//   dividers (pixel from pitch, then chip from pixels per chip), then goes
//   through the multiply, key and table update states
//   a flush gives one beat a cycle while the receiver is ready, as the
//   chain shifts its entries towards cell 0
// reset
//   table empty, hit index and overflow flag cleared, registers at defaults;
//   table contents need no clearing since only filled cells are compared
// back-pressure
//   a stalled result holds in the output register and the flush pauses;
//   in_ch.ready is low whenever an item is still being worked on

module pixel_hit_accumulator
    import pha_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    pha_hit_if.sink   in_ch,
    pha_res_if.source out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int UW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV1, ST_DIV2, ST_MUL, ST_KEY, ST_UPD, ST_FLUSH
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] pitch_x_reg;
    logic [15:0] pitch_y_reg;
    logic [7:0]  cols_reg;
    logic [7:0]  rows_reg;
    logic [7:0]  chips_reg;

    // event bookkeeping
    logic [UW-1:0]    used_reg;
    logic [IDX_W-1:0] hit_index_reg;
    logic             overflow_reg;

    // hit work registers
    logic [15:0]      sensor_reg;
    logic [15:0]      chip_col_reg;
    logic [15:0]      chip_row_reg;
    logic [7:0]       col_reg;
    logic [7:0]       row_reg;
    logic [23:0]      prod_reg;
    logic [KEY_W-1:0] key_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] o_sensor_reg;
    logic [15:0] o_chip_reg;
    logic [7:0]  o_col_reg;
    logic [7:0]  o_row_reg;
    logic [15:0] o_count_reg;
    logic [15:0] o_first_reg;
    logic        o_entry_reg;
    logic        o_ovf_reg;
    logic        o_last_reg;

    // dividers, x and y side by side
    logic        div_start;
    logic [15:0] dx_a, dx_b, dy_a, dy_b;
    logic        dx_done, dy_done;
    logic [15:0] qx, rx, qy, ry;

    logic        hit_acc, flush_acc, slot_free, full;
    logic [24:0] chip_sum;
    logic [15:0] chip_sat;

    cell_ctrl_t               ctrl;
    entry_t                   ents [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   occ;
    logic [TABLE_DEPTH-1:0]   match_vec;
    logic                     found;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign hit_acc     = in_ch.valid && in_ch.ready && (in_ch.action == ACT_HIT);
    assign flush_acc   = in_ch.valid && in_ch.ready && (in_ch.action == ACT_FLUSH);
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign full        = (used_reg == UW'(TABLE_DEPTH));
    assign found       = |match_vec;

    // first pass divides by pitch, second by pixels per chip
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            dx_a = in_ch.local_x_um;
            dx_b = nz16(pitch_x_reg);
            dy_a = in_ch.local_y_um;
            dy_b = nz16(pitch_y_reg);
        end
        else
        begin
            dx_a = qx;
            dx_b = nz16({8'd0, cols_reg});
            dy_a = qy;
            dy_b = nz16({8'd0, rows_reg});
        end
        div_start = hit_acc || (state_reg == ST_DIV1 && dx_done);
    end

    pha_div u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dx_a), .divisor(dx_b),
        .done(dx_done), .quotient(qx), .remainder(rx)
    );

    pha_div u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dy_a), .divisor(dy_b),
        .done(dy_done), .quotient(qy), .remainder(ry)
    );

    // chip id with saturation
    assign chip_sum = {1'b0, prod_reg} + {9'd0, chip_row_reg} + 25'd1;
    assign chip_sat = (chip_sum > 25'd65535) ? 16'hFFFF : chip_sum[15:0];

    // table control broadcast along the chain
    always_comb
    begin
        ctrl.update = (state_reg == ST_UPD);
        ctrl.insert = (state_reg == ST_UPD) && !found;
        ctrl.shift  = (state_reg == ST_FLUSH) && slot_free && (used_reg != '0);
        ctrl.key    = key_reg;
        ctrl.first  = hit_index_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t nbr;
            logic   prev;
            assign occ[gi] = (used_reg > UW'(gi));
            if (gi == TABLE_DEPTH - 1)
            begin : g_end
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = ents[gi + 1];
            end
            if (gi == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_rest
                assign prev = occ[gi - 1];
            end
            pha_cell u_cell (
                .clk(clk), .occ(occ[gi]), .prev_occ(prev), .ctrl(ctrl),
                .nbr(nbr), .ent(ents[gi]), .match(match_vec[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pitch_x_reg   <= 16'd50;
            pitch_y_reg   <= 16'd50;
            cols_reg      <= 8'd128;
            rows_reg      <= 8'd128;
            chips_reg     <= 8'd1;
            used_reg      <= '0;
            hit_index_reg <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PITCH_X: pitch_x_reg <= cfg_data;
                    CFG_PITCH_Y: pitch_y_reg <= cfg_data;
                    CFG_COLS:    cols_reg    <= cfg_data[7:0];
                    CFG_ROWS:    rows_reg    <= cfg_data[7:0];
                    CFG_CHIPS:   chips_reg   <= cfg_data[7:0];
                    default:     ;
                endcase
            end

            // a new beat loads the slot, otherwise a taken beat empties it
            if (state_reg == ST_FLUSH && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (hit_acc)
                        state_reg <= ST_DIV1;
                    else if (flush_acc)
                        state_reg <= ST_FLUSH;
                end
                ST_DIV1:
                begin
                    if (dx_done)
                        state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    if (dx_done)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                    state_reg <= ST_KEY;
                ST_KEY:
                    state_reg <= ST_UPD;
                ST_UPD:
                begin
                    if (!found)
                    begin
                        if (full)
                            overflow_reg <= 1'b1;
                        else
                            used_reg <= used_reg + UW'(1);
                    end
                    hit_index_reg <= hit_index_reg + IDX_W'(1);
                    state_reg     <= ST_IDLE;
                end
                ST_FLUSH:
                begin
                    if (slot_free)
                    begin
                        if (used_reg == '0 || used_reg == UW'(1))
                        begin
                            used_reg      <= '0;
                            hit_index_reg <= '0;
                            overflow_reg  <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                            used_reg <= used_reg - UW'(1);
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (hit_acc)
            sensor_reg <= in_ch.sensor_id;
        if (state_reg == ST_DIV1 && dx_done)
        begin
            // pixel column and row now feed the second pass
        end
        if (state_reg == ST_DIV2 && dx_done)
        begin
            chip_col_reg <= qx;
            chip_row_reg <= qy;
            col_reg      <= rx[7:0];
            row_reg      <= ry[7:0];
        end
        if (state_reg == ST_MUL)
            prod_reg <= {8'd0, chip_col_reg} * {16'd0, chips_reg};
        if (state_reg == ST_KEY)
            key_reg <= {sensor_reg, chip_sat, col_reg, row_reg};
        if (state_reg == ST_FLUSH && slot_free)
        begin
            o_ovf_reg  <= overflow_reg;
            o_last_reg <= (used_reg == '0 || used_reg == UW'(1));
            if (used_reg == '0)
            begin
                o_sensor_reg <= '0;
                o_chip_reg   <= '0;
                o_col_reg    <= '0;
                o_row_reg    <= '0;
                o_count_reg  <= '0;
                o_first_reg  <= '0;
                o_entry_reg  <= 1'b0;
            end
            else
            begin
                o_sensor_reg <= ents[0].key[47:32];
                o_chip_reg   <= ents[0].key[31:16];
                o_col_reg    <= ents[0].key[15:8];
                o_row_reg    <= ents[0].key[7:0];
                o_count_reg  <= ents[0].count;
                o_first_reg  <= ents[0].first;
                o_entry_reg  <= 1'b1;
            end
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.out_sensor_id   = o_sensor_reg;
    assign out_ch.chip_id         = o_chip_reg;
    assign out_ch.pixel_col       = o_col_reg;
    assign out_ch.pixel_row       = o_row_reg;
    assign out_ch.hit_count       = o_count_reg;
    assign out_ch.first_hit_index = o_first_reg;
    assign out_ch.entry_valid     = o_entry_reg;
    assign out_ch.overflow        = o_ovf_reg;
    assign out_ch.last            = o_last_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("table fill beyond depth");

    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("pixel held in more than one cell");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg) == ST_FLUSH) |-> (used_reg == '0))
        else $error("table not empty after final flush beat");

    a_xy_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_done == dy_done)
        else $error("dividers out of step");
`endif
endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for the pixel hit accumulator
// depends on pha_pkg, pha_if and the pixel_hit_accumulator rtl
`timescale 1ns / 1ps

module testbench;
    import pha_pkg::*;

    // one beat on the result channel, as the bench sees it
    typedef struct {
        logic [15:0] sensor;
        logic [15:0] chip;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] count;
        logic [15:0] first;
        logic        entry;
        logic        ovf;
        logic        last;
    } pixel_beat_t;

    // event table model plus the queue of beats still owed by the block
    class accum_scoreboard;
        logic [15:0] pitch_x;
        logic [15:0] pitch_y;
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic [7:0]  chips;
        logic [47:0] keys [64];
        logic [15:0] counts [64];
        logic [15:0] firsts [64];
        int          used;
        logic [15:0] hit_idx;
        bit          ovf;
        pixel_beat_t awaited [$];
        int          errors;
        int          hits;
        int          flushes;
        int          beats;
        int          ovf_events;

        function new();
            pitch_x = 50;
            pitch_y = 50;
            cols = 128;
            rows = 128;
            chips = 1;
            used = 0;
            hit_idx = 0;
            ovf = 0;
            errors = 0;
            hits = 0;
            flushes = 0;
            beats = 0;
            ovf_events = 0;
        endfunction

        function int unsigned nz(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                CFG_PITCH_X: pitch_x = v;
                CFG_PITCH_Y: pitch_y = v;
                CFG_COLS:    cols = v[7:0];
                CFG_ROWS:    rows = v[7:0];
                CFG_CHIPS:   chips = v[7:0];
                default: ;
            endcase
        endfunction

        // notes an accepted input beat and queues the beats it causes
        function void note_item(logic act, logic [15:0] s, logic [15:0] x, logic [15:0] y);
            int unsigned gcol;
            int unsigned grow;
            int unsigned cpc;
            int unsigned rpc;
            int unsigned chip;
            logic [47:0] k;
            bit          found;
            pixel_beat_t r;
            if (act == ACT_FLUSH) begin
                flushes++;
                if (ovf)
                    ovf_events++;
                if (used == 0) begin
                    r = '{16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, ovf, 1'b1};
                    awaited.push_back(r);
                end
                for (int i = 0; i < used; i++) begin
                    r.sensor = keys[i][47:32];
                    r.chip = keys[i][31:16];
                    r.col = keys[i][15:8];
                    r.row = keys[i][7:0];
                    r.count = counts[i];
                    r.first = firsts[i];
                    r.entry = 1'b1;
                    r.ovf = ovf;
                    r.last = (i + 1 == used);
                    awaited.push_back(r);
                end
                used = 0;
                hit_idx = 0;
                ovf = 0;
                return;
            end
            hits++;
            gcol = x / nz(pitch_x);
            grow = y / nz(pitch_y);
            cpc = nz(cols);
            rpc = nz(rows);
            chip = 1 + (gcol / cpc) * chips + grow / rpc;
            if (chip > 65535)
                chip = 65535;
            k = {s, chip[15:0], 8'(gcol % cpc), 8'(grow % rpc)};
            found = 0;
            for (int i = 0; i < used; i++) begin
                if (keys[i] == k) begin
                    found = 1;
                    if (counts[i] != 16'hffff)
                        counts[i]++;
                end
            end
            if (!found) begin
                if (used < 64) begin
                    keys[used] = k;
                    counts[used] = 1;
                    firsts[used] = hit_idx;
                    used++;
                end
                else
                    ovf = 1;
            end
            hit_idx++;
        endfunction

        function void field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_beat(pixel_beat_t got);
            pixel_beat_t e;
            if (awaited.size() == 0) begin
                $error("result beat with nothing expected (sensor %0d)", got.sensor);
                errors++;
                return;
            end
            e = awaited.pop_front();
            beats++;
            field("out_sensor_id", e.sensor, got.sensor);
            field("chip_id", e.chip, got.chip);
            field("pixel_col", e.col, got.col);
            field("pixel_row", e.row, got.row);
            field("hit_count", e.count, got.count);
            field("first_hit_index", e.first, got.first);
            field("entry_valid", e.entry, got.entry);
            field("overflow", e.ovf, got.ovf);
            field("last", e.last, got.last);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    pha_hit_if hit_ch ();
    pha_res_if res_ch ();

    pixel_hit_accumulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (hit_ch.sink),
        .out_ch    (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    accum_scoreboard sb = new();

    // quiet: no idling on either side; hold_cycles: long receiver stall request
    bit quiet;
    int hold_cycles;
    int items_sent;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // beats are sampled at the rising edge, inputs change on the falling one
    always @(posedge clk)
    begin
        if (rst_n && hit_ch.valid && hit_ch.ready)
            sb.note_item(hit_ch.action, hit_ch.sensor_id, hit_ch.local_x_um, hit_ch.local_y_um);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_beat('{res_ch.out_sensor_id, res_ch.chip_id, res_ch.pixel_col,
                            res_ch.pixel_row, res_ch.hit_count, res_ch.first_hit_index,
                            res_ch.entry_valid, res_ch.overflow, res_ch.last});
    end

    // receiver: random stalls, plus the long hold-off counted here
    initial
    begin
        int idle_left;
        idle_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (idle_left > 0 && !quiet)
            begin
                res_ch.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                idle_left = 0;
                if ($urandom_range(0, 3) == 0)
                    idle_left = pick_gap();
            end
        end
    end

    // offer one beat from a falling edge, wait for the handshake, then maybe idle
    task automatic send_item(logic act, logic [15:0] s, logic [15:0] x, logic [15:0] y);
        int g;
        hit_ch.valid <= 1'b1;
        hit_ch.action <= act;
        hit_ch.sensor_id <= s;
        hit_ch.local_x_um <= x;
        hit_ch.local_y_um <= y;
        @(posedge clk);
        while (!hit_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        g = (quiet || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
        if (g > 0)
        begin
            hit_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // pause the sender until every owed beat is back, then let a hit finish
    task automatic drain();
        hit_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [15:0] px, logic [15:0] py, logic [7:0] c,
                                logic [7:0] r, logic [7:0] ch);
        write_reg(CFG_PITCH_X, px);
        write_reg(CFG_PITCH_Y, py);
        write_reg(CFG_COLS, {8'd0, c});
        write_reg(CFG_ROWS, {8'd0, r});
        write_reg(CFG_CHIPS, {8'd0, ch});
    endtask

    // one event: hits partly drawn from a small pool so pixels repeat (all fresh when distinct is set), then a flush
    task automatic run_event(int n, bit distinct);
        logic [15:0] ps [6];
        logic [15:0] pxs [6];
        logic [15:0] pys [6];
        int j;
        for (int i = 0; i < 6; i++)
        begin
            ps[i] = $urandom_range(0, 65535);
            pxs[i] = $urandom_range(0, 65535);
            pys[i] = $urandom_range(0, 65535);
        end
        for (int i = 0; i < n; i++)
        begin
            if (distinct || $urandom_range(0, 2) == 0)
                send_item(ACT_HIT, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            else
            begin
                j = $urandom_range(0, 5);
                send_item(ACT_HIT, ps[j], pxs[j], pys[j]);
            end
        end
        send_item(ACT_FLUSH, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
    endtask

    initial
    begin
        int budget;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PITCH_X;
        cfg_data = 16'd0;
        hit_ch.valid = 1'b0;
        hit_ch.action = ACT_HIT;
        hit_ch.sensor_id = 16'd0;
        hit_ch.local_x_um = 16'd0;
        hit_ch.local_y_um = 16'd0;
        quiet = 0;
        hold_cycles = 0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset geometry, field extremes, a repeated pixel
        send_item(ACT_HIT, 16'd0, 16'd0, 16'd0);
        send_item(ACT_HIT, 16'hffff, 16'hffff, 16'hffff);
        send_item(ACT_HIT, 16'd0, 16'd49, 16'd49);
        send_item(ACT_HIT, 16'haaaa, 16'd50, 16'h5555);
        send_item(ACT_FLUSH, 16'd0, 16'd0, 16'd0);
        // empty flush straight after a flush
        send_item(ACT_FLUSH, 16'hffff, 16'hffff, 16'hffff);
        drain();

        // zero registers: pitches and chip size read as one, chip stacking as zero
        set_geometry(16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_item(ACT_HIT, 16'd7, 16'd3, 16'd5);
        send_item(ACT_HIT, 16'd7, 16'd3, 16'd5);
        send_item(ACT_HIT, 16'd7, 16'd300, 16'd2);
        send_item(ACT_FLUSH, 16'd0, 16'd0, 16'd0);
        drain();

        // chip id past the 16-bit range saturates
        set_geometry(16'd1, 16'd1, 8'd1, 8'd1, 8'd255);
        send_item(ACT_HIT, 16'd1, 16'hffff, 16'hffff);
        send_item(ACT_HIT, 16'd1, 16'd1, 16'd0);
        send_item(ACT_HIT, 16'd1, 16'd0, 16'd300);
        send_item(ACT_FLUSH, 16'd0, 16'd0, 16'd0);
        drain();

        // long receiver hold while the sender keeps offering: the block backs up
        set_geometry(16'd50, 16'd50, 8'd128, 8'd128, 8'd1);
        send_item(ACT_HIT, 16'd2, 16'd1000, 16'd2000);
        send_item(ACT_HIT, 16'd3, 16'd1100, 16'd2100);
        hold_cycles = 300;
        send_item(ACT_FLUSH, 16'd0, 16'd0, 16'd0);
        send_item(ACT_HIT, 16'd4, 16'd10, 16'd20);
        send_item(ACT_HIT, 16'd4, 16'd10, 16'd20);
        send_item(ACT_FLUSH, 16'd0, 16'd0, 16'd0);
        drain();

        // random phases, each with its own geometry
        for (int ph = 0; ph < 8; ph++)
        begin
            quiet = (ph == 2);
            case (ph)
                0: set_geometry($urandom_range(20, 200), $urandom_range(20, 200),
                                $urandom_range(16, 128), $urandom_range(16, 128),
                                $urandom_range(1, 8));
                1: set_geometry(16'hffff, 16'hffff, 8'd255, 8'd255, 8'd255);
                2: set_geometry(16'd1, 16'd1, 8'd1, 8'd1, 8'd1);
                3: set_geometry(16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
                default: set_geometry($urandom_range(0, 65535), $urandom_range(0, 65535),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255));
            endcase
            budget = items_sent + 30;
            // table overflow: more distinct pixels than the table holds
            if (ph == 2 || ph == 5)
                run_event(70, 1);
            while (items_sent < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                    run_event(0, 0);
                else
                    run_event($urandom_range(1, 12), 0);
            end
            drain();
        end

        $display("covered %0d hits and %0d flushes, %0d result beats checked, %0d overflowed events",
                 sb.hits, sb.flushes, sb.beats, sb.ovf_events);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pha_pkg.sv
rtl/pha_if.sv
rtl/pha_div.sv
rtl/pha_cell.sv
rtl/pixel_hit_accumulator.sv
bench/testbench.sv
